### src/triangle_face_normal_defines.svh
// assertion macros used by the checker file
`ifndef TRIANGLE_FACE_NORMAL_DEFINES_SVH
`define TRIANGLE_FACE_NORMAL_DEFINES_SVH

// condition must hold in the same cycle as the trigger
`define TFN_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// condition must hold in the cycle after the trigger
`define TFN_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/tfn_pkg.sv
// shared constants, types and codes of the face normal pipeline
package tfn_pkg;

   // vertex store
   localparam int VERTS_MAX = 1024;
   localparam int ADDR_W = $clog2(VERTS_MAX);
   localparam int IDX_W = 16;
   localparam int LIM_W = IDX_W + 1;
   localparam int CNT_W = 11;

   // datapath widths
   localparam int COORD_W = 24;
   localparam int VERT_W = 3 * COORD_W;
   localparam int EDGE_W = COORD_W + 1;
   localparam int PROD_W = 2 * EDGE_W;
   localparam int CROSS_W = PROD_W + 1;
   localparam int MAG_W = CROSS_W - 1;
   localparam int SHIFT_W = $clog2(MAG_W + 1);
   localparam int NM_W = 30;
   localparam int NM_TOP = NM_W - 1;
   localparam int SQ_W = 2 * NM_W;
   localparam int SUM_W = SQ_W + 2;
   localparam int ROOT_W = SUM_W / 2;
   localparam int ISQ_STEPS = ROOT_W;
   localparam int FRAC_OUT = 14;
   localparam int Q_W = FRAC_OUT + 1;
   localparam int DIV_STEPS = Q_W;
   localparam int NUM_W = NM_W + FRAC_OUT + 1;
   localparam int REM_W = NUM_W + 1;
   localparam int OUT_W = 16;

   // register port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-3:0] CSR_IDX_VERTEX_COUNT = '0;

   // operation codes
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_FACE = 1'b1;

   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_WRITTEN = 2'd1,
      STAT_BAD     = 2'd2,
      STAT_DEGEN   = 2'd3
   } status_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } vertex_type;

   // control that travels with every stage
   typedef struct packed {
      logic       valid;
      logic       calc;
      status_type status;
      logic       last;
   } ctrl_type;

   typedef struct packed {
      ctrl_type                  ctrl;
      logic [2:0]                neg;
      logic [2:0][MAG_W-1:0]     mag;
   } cross_type;

   typedef struct packed {
      ctrl_type                  ctrl;
      logic [2:0]                neg;
      logic [2:0][NM_W-1:0]      m;
      logic [ROOT_W-1:0]         root;
   } root_type;

   typedef struct packed {
      ctrl_type                  ctrl;
      logic [2:0]                neg;
      logic [2:0][Q_W-1:0]       q;
   } quot_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] normal_x;
      logic signed [OUT_W-1:0] normal_y;
      logic signed [OUT_W-1:0] normal_z;
      status_type              status;
      logic                    last;
   } result_type;

   // apply sign to a quotient magnitude
   function automatic logic [OUT_W-1:0] signed_q(input logic neg, input logic [Q_W-1:0] q);
      logic [OUT_W-1:0] ext;
      ext = OUT_W'(q);
      return neg ? (OUT_W'(0) - ext) : ext;
   endfunction

endpackage

### src/tfn_ifs.sv
// valid/ready channel interfaces for request and result beats
interface tfn_req_if;
   logic                                     valid;
   logic                                     ready;
   logic                                     op;
   logic [tfn_pkg::IDX_W-1:0]                corner_a;
   logic [tfn_pkg::IDX_W-1:0]                corner_b;
   logic [tfn_pkg::IDX_W-1:0]                corner_c;
   logic signed [tfn_pkg::COORD_W-1:0]       pos_x;
   logic signed [tfn_pkg::COORD_W-1:0]       pos_y;
   logic signed [tfn_pkg::COORD_W-1:0]       pos_z;
   logic                                     last_face;

   modport source (output valid, op, corner_a, corner_b, corner_c, pos_x, pos_y, pos_z,
                   last_face, input ready);
   modport sink (input valid, op, corner_a, corner_b, corner_c, pos_x, pos_y, pos_z,
                 last_face, output ready);
endinterface

interface tfn_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [tfn_pkg::OUT_W-1:0]    normal_x;
   logic signed [tfn_pkg::OUT_W-1:0]    normal_y;
   logic signed [tfn_pkg::OUT_W-1:0]    normal_z;
   logic [1:0]                          status;
   logic                                last_out;

   modport source (output valid, normal_x, normal_y, normal_z, status, last_out, input ready);
   modport sink (input valid, normal_x, normal_y, normal_z, status, last_out, output ready);
endinterface

### src/triangle_face_normal.sv
// Throughput: one request beat per cycle while no skid entry is held; the square root
// (31 stages) and the divider (15 stages) are fully pipelined, so every stage takes
// a new item each cycle.
// A stalled output fills one skid register, then holds the whole pipeline.
// Synchronous active-high reset clears valid bits and vertex_count; the vertex
// store holds no reset value and needs no clearing pass.
module triangle_face_normal (
   input  logic                           clock,
   input  logic                           reset,
   tfn_req_if.sink                        req_ch,
   tfn_rsp_if.source                      rsp_ch,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [tfn_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [tfn_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [tfn_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);

   logic [tfn_pkg::CNT_W-1:0] vertex_count_ff;
   logic                      csr_sel_vc;
   logic                      adv, fire, is_face, bad_face, wr_ok;
   logic [tfn_pkg::LIM_W-1:0] limit;
   tfn_pkg::ctrl_type         ctrl_in;
   tfn_pkg::vertex_type       wr_data;
   tfn_pkg::cross_type        cross_s;
   tfn_pkg::root_type         root_s;
   tfn_pkg::quot_type         quot_s;
   tfn_pkg::result_type       res_in, out_ff, skid_ff;
   logic                      out_valid_ff, skid_valid_ff;

   // register port
   assign csr_pready = 1'b1;
   assign csr_sel_vc = (csr_paddr[tfn_pkg::CSR_ADDR_W-1:2] == tfn_pkg::CSR_IDX_VERTEX_COUNT);
   assign csr_prdata = csr_sel_vc ? tfn_pkg::CSR_DATA_W'(vertex_count_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_sel_vc) begin
         vertex_count_ff <= csr_pwdata[tfn_pkg::CNT_W-1:0];
      end
   end

   // entry checks on the accepted beat
   assign adv = !skid_valid_ff;
   assign req_ch.ready = adv;
   assign fire = req_ch.valid && adv;
   assign is_face = (req_ch.op == tfn_pkg::OP_FACE);

   always_comb begin
      if (tfn_pkg::LIM_W'(vertex_count_ff) > tfn_pkg::LIM_W'(tfn_pkg::VERTS_MAX)) begin
         limit = tfn_pkg::LIM_W'(tfn_pkg::VERTS_MAX);
      end else begin
         limit = tfn_pkg::LIM_W'(vertex_count_ff);
      end
      bad_face = (tfn_pkg::LIM_W'(req_ch.corner_a) >= limit)
                 || (tfn_pkg::LIM_W'(req_ch.corner_b) >= limit)
                 || (tfn_pkg::LIM_W'(req_ch.corner_c) >= limit);
      wr_ok = tfn_pkg::LIM_W'(req_ch.corner_a) < tfn_pkg::LIM_W'(tfn_pkg::VERTS_MAX);
      ctrl_in.valid = fire;
      ctrl_in.last = req_ch.last_face;
      ctrl_in.calc = is_face && !bad_face;
      if (is_face) begin
         ctrl_in.status = bad_face ? tfn_pkg::STAT_BAD : tfn_pkg::STAT_OK;
      end else begin
         ctrl_in.status = wr_ok ? tfn_pkg::STAT_WRITTEN : tfn_pkg::STAT_BAD;
      end
   end

   assign wr_data.x = req_ch.pos_x;
   assign wr_data.y = req_ch.pos_y;
   assign wr_data.z = req_ch.pos_z;

   tfn_front u_front (
      .clock(clock),
      .reset(reset),
      .adv(adv),
      .wr_en(fire && (req_ch.op == tfn_pkg::OP_WRITE) && wr_ok),
      .wr_addr(req_ch.corner_a[tfn_pkg::ADDR_W-1:0]),
      .wr_data(wr_data),
      .rd_addr_a(req_ch.corner_a[tfn_pkg::ADDR_W-1:0]),
      .rd_addr_b(req_ch.corner_b[tfn_pkg::ADDR_W-1:0]),
      .rd_addr_c(req_ch.corner_c[tfn_pkg::ADDR_W-1:0]),
      .ctrl_in(ctrl_in),
      .cross_out(cross_s)
   );

   tfn_norm u_norm (
      .clock(clock),
      .reset(reset),
      .adv(adv),
      .cross_in(cross_s),
      .root_out(root_s)
   );

   tfn_div u_div (
      .clock(clock),
      .reset(reset),
      .adv(adv),
      .root_in(root_s),
      .quot_out(quot_s)
   );

   // final signs, zero normal for everything but a good face
   always_comb begin
      res_in.status = quot_s.ctrl.status;
      res_in.last = quot_s.ctrl.last;
      res_in.normal_x = '0;
      res_in.normal_y = '0;
      res_in.normal_z = '0;
      if (quot_s.ctrl.calc) begin
         res_in.normal_x = tfn_pkg::signed_q(quot_s.neg[0], quot_s.q[0]);
         res_in.normal_y = tfn_pkg::signed_q(quot_s.neg[1], quot_s.q[1]);
         res_in.normal_z = tfn_pkg::signed_q(quot_s.neg[2], quot_s.q[2]);
      end
   end

   // output register with one skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_ch.ready) begin
         if (skid_valid_ff) begin
            out_valid_ff <= 1'b1;
            out_ff <= skid_ff;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= quot_s.ctrl.valid;
            out_ff <= res_in;
         end
      end else if (adv && quot_s.ctrl.valid) begin
         skid_valid_ff <= 1'b1;
         skid_ff <= res_in;
      end
   end

   assign rsp_ch.valid = out_valid_ff;
   assign rsp_ch.normal_x = out_ff.normal_x;
   assign rsp_ch.normal_y = out_ff.normal_y;
   assign rsp_ch.normal_z = out_ff.normal_z;
   assign rsp_ch.status = out_ff.status;
   assign rsp_ch.last_out = out_ff.last;

endmodule

### src/tfn_ram.sv
// generic single write port ram with registered read
module tfn_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/tfn_front.sv
// vertex store, edge vectors, cross product and magnitudes
module tfn_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       adv,
   input  logic                       wr_en,
   input  logic [tfn_pkg::ADDR_W-1:0] wr_addr,
   input  tfn_pkg::vertex_type        wr_data,
   input  logic [tfn_pkg::ADDR_W-1:0] rd_addr_a,
   input  logic [tfn_pkg::ADDR_W-1:0] rd_addr_b,
   input  logic [tfn_pkg::ADDR_W-1:0] rd_addr_c,
   input  tfn_pkg::ctrl_type          ctrl_in,
   output tfn_pkg::cross_type         cross_out
);

   tfn_pkg::vertex_type va, vb, vc;
   tfn_pkg::ctrl_type ctrl_a_ff, ctrl_b_ff, ctrl_c_ff, ctrl_d_ff, ctrl_e_ff;
   logic signed [tfn_pkg::EDGE_W-1:0]  e1_ff [3];
   logic signed [tfn_pkg::EDGE_W-1:0]  e2_ff [3];
   logic signed [tfn_pkg::PROD_W-1:0]  prod_ff [6];
   logic signed [tfn_pkg::CROSS_W-1:0] cross_ff [3];
   logic [tfn_pkg::CROSS_W-1:0]        mag_full [3];
   logic [2:0]                         neg_in, neg_ff;
   logic [2:0][tfn_pkg::MAG_W-1:0]     mag_in, mag_ff;

   // three copies of the store, one per corner read
   tfn_ram #(.WIDTH(tfn_pkg::VERT_W), .DEPTH(tfn_pkg::VERTS_MAX)) u_ram_a (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_en(adv), .rd_addr(rd_addr_a), .rd_data(va)
   );
   tfn_ram #(.WIDTH(tfn_pkg::VERT_W), .DEPTH(tfn_pkg::VERTS_MAX)) u_ram_b (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_en(adv), .rd_addr(rd_addr_b), .rd_data(vb)
   );
   tfn_ram #(.WIDTH(tfn_pkg::VERT_W), .DEPTH(tfn_pkg::VERTS_MAX)) u_ram_c (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_en(adv), .rd_addr(rd_addr_c), .rd_data(vc)
   );

   // magnitude and sign of each cross component
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         neg_in[k] = cross_ff[k][tfn_pkg::CROSS_W-1];
         mag_full[k] = neg_in[k] ? (tfn_pkg::CROSS_W'(0) - cross_ff[k]) : cross_ff[k];
         mag_in[k] = mag_full[k][tfn_pkg::MAG_W-1:0];
      end
   end

   // edges, products, cross terms, magnitudes
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_a_ff <= '0;
         ctrl_b_ff <= '0;
         ctrl_c_ff <= '0;
         ctrl_d_ff <= '0;
         ctrl_e_ff <= '0;
      end else if (adv) begin
         ctrl_a_ff <= ctrl_in;
         ctrl_b_ff <= ctrl_a_ff;
         ctrl_c_ff <= ctrl_b_ff;
         ctrl_d_ff <= ctrl_c_ff;
         ctrl_e_ff <= ctrl_d_ff;

         e1_ff[0] <= tfn_pkg::EDGE_W'(vb.x) - tfn_pkg::EDGE_W'(va.x);
         e1_ff[1] <= tfn_pkg::EDGE_W'(vb.y) - tfn_pkg::EDGE_W'(va.y);
         e1_ff[2] <= tfn_pkg::EDGE_W'(vb.z) - tfn_pkg::EDGE_W'(va.z);
         e2_ff[0] <= tfn_pkg::EDGE_W'(vc.x) - tfn_pkg::EDGE_W'(va.x);
         e2_ff[1] <= tfn_pkg::EDGE_W'(vc.y) - tfn_pkg::EDGE_W'(va.y);
         e2_ff[2] <= tfn_pkg::EDGE_W'(vc.z) - tfn_pkg::EDGE_W'(va.z);

         prod_ff[0] <= e1_ff[1] * e2_ff[2];
         prod_ff[1] <= e1_ff[2] * e2_ff[1];
         prod_ff[2] <= e1_ff[2] * e2_ff[0];
         prod_ff[3] <= e1_ff[0] * e2_ff[2];
         prod_ff[4] <= e1_ff[0] * e2_ff[1];
         prod_ff[5] <= e1_ff[1] * e2_ff[0];

         cross_ff[0] <= tfn_pkg::CROSS_W'(prod_ff[0]) - tfn_pkg::CROSS_W'(prod_ff[1]);
         cross_ff[1] <= tfn_pkg::CROSS_W'(prod_ff[2]) - tfn_pkg::CROSS_W'(prod_ff[3]);
         cross_ff[2] <= tfn_pkg::CROSS_W'(prod_ff[4]) - tfn_pkg::CROSS_W'(prod_ff[5]);

         neg_ff <= neg_in;
         mag_ff <= mag_in;
      end
   end

   assign cross_out.ctrl = ctrl_e_ff;
   assign cross_out.neg = neg_ff;
   assign cross_out.mag = mag_ff;

endmodule

### src/tfn_norm.sv
// common scaling, sum of squares and pipelined integer square root
module tfn_norm (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  tfn_pkg::cross_type cross_in,
   output tfn_pkg::root_type  root_out
);

   localparam int STEPS = tfn_pkg::ISQ_STEPS;

   logic [tfn_pkg::MAG_W-1:0]   any;
   logic [tfn_pkg::SHIFT_W-1:0] msb;
   tfn_pkg::ctrl_type           ctrl1_in;
   logic                        right_in;
   logic [tfn_pkg::SHIFT_W-1:0] amt_in;

   tfn_pkg::ctrl_type              ctrl1_ff, ctrl2_ff, ctrl3_ff;
   logic [2:0]                     neg1_ff, neg2_ff, neg3_ff;
   logic [2:0][tfn_pkg::MAG_W-1:0] mag1_ff;
   logic                           right_ff;
   logic [tfn_pkg::SHIFT_W-1:0]    amt_ff;
   logic [tfn_pkg::MAG_W-1:0]      sh [3];
   logic [2:0][tfn_pkg::NM_W-1:0]  m_in, m2_ff, m3_ff;
   logic [tfn_pkg::SQ_W-1:0]       sq_ff [3];

   tfn_pkg::ctrl_type             qc_ff   [STEPS+1];
   logic [2:0]                    qn_ff   [STEPS+1];
   logic [2:0][tfn_pkg::NM_W-1:0] qm_ff   [STEPS+1];
   logic [tfn_pkg::SUM_W-1:0]     rem_ff  [STEPS+1];
   logic [tfn_pkg::SUM_W-1:0]     root_ff [STEPS+1];

   // leading one of the largest magnitude and the shift that brings it to bit 29
   always_comb begin
      any = cross_in.mag[0] | cross_in.mag[1] | cross_in.mag[2];
      msb = '0;
      for (int i = 0; i < tfn_pkg::MAG_W; i++) begin
         if (any[i]) begin
            msb = tfn_pkg::SHIFT_W'(i);
         end
      end
      ctrl1_in = cross_in.ctrl;
      if (cross_in.ctrl.calc && (any == '0)) begin
         ctrl1_in.status = tfn_pkg::STAT_DEGEN;
         ctrl1_in.calc = 1'b0;
      end
      if (msb > tfn_pkg::SHIFT_W'(tfn_pkg::NM_TOP)) begin
         right_in = 1'b1;
         amt_in = msb - tfn_pkg::SHIFT_W'(tfn_pkg::NM_TOP);
      end else begin
         right_in = 1'b0;
         amt_in = tfn_pkg::SHIFT_W'(tfn_pkg::NM_TOP) - msb;
      end
   end

   // shift all three magnitudes by the common amount
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sh[k] = right_ff ? (mag1_ff[k] >> amt_ff) : (mag1_ff[k] << amt_ff);
         m_in[k] = sh[k][tfn_pkg::NM_W-1:0];
      end
   end

   // scale, square and sum stages
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl1_ff <= '0;
         ctrl2_ff <= '0;
         ctrl3_ff <= '0;
         qc_ff[0] <= '0;
      end else if (adv) begin
         ctrl1_ff <= ctrl1_in;
         neg1_ff <= cross_in.neg;
         mag1_ff <= cross_in.mag;
         right_ff <= right_in;
         amt_ff <= amt_in;

         ctrl2_ff <= ctrl1_ff;
         neg2_ff <= neg1_ff;
         m2_ff <= m_in;

         ctrl3_ff <= ctrl2_ff;
         neg3_ff <= neg2_ff;
         m3_ff <= m2_ff;
         for (int k = 0; k < 3; k++) begin
            sq_ff[k] <= m2_ff[k] * m2_ff[k];
         end

         qc_ff[0] <= ctrl3_ff;
         qn_ff[0] <= neg3_ff;
         qm_ff[0] <= m3_ff;
         rem_ff[0] <= tfn_pkg::SUM_W'(sq_ff[0]) + tfn_pkg::SUM_W'(sq_ff[1])
                      + tfn_pkg::SUM_W'(sq_ff[2]);
         root_ff[0] <= '0;
      end
   end

   // one root bit per stage
   for (genvar k = 0; k < STEPS; k++) begin : g_isq
      localparam int BIT_POS = 2 * (STEPS - 1 - k);
      logic [tfn_pkg::SUM_W-1:0] bit_val, trial, rem_in, root_in;

      always_comb begin
         bit_val = tfn_pkg::SUM_W'(1) << BIT_POS;
         trial = root_ff[k] + bit_val;
         if (rem_ff[k] >= trial) begin
            rem_in = rem_ff[k] - trial;
            root_in = (root_ff[k] >> 1) + bit_val;
         end else begin
            rem_in = rem_ff[k];
            root_in = root_ff[k] >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            qc_ff[k+1] <= '0;
         end else if (adv) begin
            qc_ff[k+1] <= qc_ff[k];
            qn_ff[k+1] <= qn_ff[k];
            qm_ff[k+1] <= qm_ff[k];
            rem_ff[k+1] <= rem_in;
            root_ff[k+1] <= root_in;
         end
      end
   end

   assign root_out.ctrl = qc_ff[STEPS];
   assign root_out.neg = qn_ff[STEPS];
   assign root_out.m = qm_ff[STEPS];
   assign root_out.root = root_ff[STEPS][tfn_pkg::ROOT_W-1:0];

endmodule

### src/tfn_div.sv
// three-lane restoring divider, one quotient bit per stage
module tfn_div (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  tfn_pkg::root_type root_in,
   output tfn_pkg::quot_type quot_out
);

   localparam int STEPS = tfn_pkg::DIV_STEPS;

   tfn_pkg::ctrl_type              dc_ff   [STEPS+1];
   logic [2:0]                     dn_ff   [STEPS+1];
   logic [tfn_pkg::ROOT_W-1:0]     dden_ff [STEPS+1];
   logic [2:0][tfn_pkg::REM_W-1:0] drem_ff [STEPS+1];
   logic [2:0][tfn_pkg::Q_W-1:0]   dq_ff   [STEPS+1];
   logic [2:0][tfn_pkg::REM_W-1:0] num_in;

   // rounded dividend: m * 2^14 + floor(root / 2)
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         num_in[k] = (tfn_pkg::REM_W'(root_in.m[k]) << tfn_pkg::FRAC_OUT)
                     + tfn_pkg::REM_W'(root_in.root >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dc_ff[0] <= '0;
      end else if (adv) begin
         dc_ff[0] <= root_in.ctrl;
         dn_ff[0] <= root_in.neg;
         dden_ff[0] <= root_in.root;
         drem_ff[0] <= num_in;
         dq_ff[0] <= '0;
      end
   end

   for (genvar i = 0; i < STEPS; i++) begin : g_div
      localparam int BP = STEPS - 1 - i;
      logic [tfn_pkg::REM_W-1:0]      dsh;
      logic [2:0][tfn_pkg::REM_W-1:0] rem_in;
      logic [2:0][tfn_pkg::Q_W-1:0]   q_in;

      always_comb begin
         dsh = tfn_pkg::REM_W'(dden_ff[i]) << BP;
         for (int k = 0; k < 3; k++) begin
            q_in[k] = dq_ff[i][k];
            if (drem_ff[i][k] >= dsh) begin
               rem_in[k] = drem_ff[i][k] - dsh;
               q_in[k][BP] = 1'b1;
            end else begin
               rem_in[k] = drem_ff[i][k];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dc_ff[i+1] <= '0;
         end else if (adv) begin
            dc_ff[i+1] <= dc_ff[i];
            dn_ff[i+1] <= dn_ff[i];
            dden_ff[i+1] <= dden_ff[i];
            drem_ff[i+1] <= rem_in;
            dq_ff[i+1] <= q_in;
         end
      end
   end

   assign quot_out.ctrl = dc_ff[STEPS];
   assign quot_out.neg = dn_ff[STEPS];
   assign quot_out.q = dq_ff[STEPS];

endmodule

### src/tfn_checker.sv
// port level checks on the face normal block and their binding
`include "triangle_face_normal_defines.svh"

module tfn_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic signed [tfn_pkg::OUT_W-1:0] normal_x,
   input logic signed [tfn_pkg::OUT_W-1:0] normal_y,
   input logic signed [tfn_pkg::OUT_W-1:0] normal_z,
   input logic [1:0]                    status
);

   logic [3*tfn_pkg::OUT_W+1:0] payload;
   logic                        normal_zero;
   logic                        rsp_ok;

   // result payload and its zero test
   assign payload = {normal_x, normal_y, normal_z, status};
   assign normal_zero = (normal_x == '0) && (normal_y == '0) && (normal_z == '0);
   assign rsp_ok = (status == tfn_pkg::STAT_OK);

   // a stalled result beat keeps its payload
   `TFN_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(payload), "stall")

   // input only stalls when a result is waiting at the output
   `TFN_ASSERT_NOW(a_stall_cause, !req_ready, rsp_valid, "input stalled with empty output")

   // anything but a good face carries a zero normal
   `TFN_ASSERT_NOW(a_zero_normal, rsp_valid && !rsp_ok, normal_zero, "nonzero normal")

   // a good face never yields an all-zero normal
   `TFN_ASSERT_NOW(a_unit_normal, rsp_valid && rsp_ok, !normal_zero, "zero normal on face")

endmodule

bind triangle_face_normal tfn_checker u_tfn_checker (
   .clock(clock),
   .reset(reset),
   .req_ready(req_ch.ready),
   .rsp_valid(rsp_ch.valid),
   .rsp_ready(rsp_ch.ready),
   .normal_x(rsp_ch.normal_x),
   .normal_y(rsp_ch.normal_y),
   .normal_z(rsp_ch.normal_z),
   .status(rsp_ch.status)
);

### tb/testbench.sv
// testbench for the triangle face normal pipeline: scoreboard, stimulus and checks
module testbench;

   // expected result of one request beat
   typedef struct {
      logic signed [15:0] nx;
      logic signed [15:0] ny;
      logic signed [15:0] nz;
      logic [1:0]         status;
      logic               last;
   } normal_exp_type;

   // scoreboard: own copy of the vertex store and count
   class normal_scoreboard;
      logic signed [23:0] vx [tfn_pkg::VERTS_MAX];
      logic signed [23:0] vy [tfn_pkg::VERTS_MAX];
      logic signed [23:0] vz [tfn_pkg::VERTS_MAX];
      logic [10:0]        vcount;
      normal_exp_type     pending [$];
      int                 errors;

      function new();
         vcount = 0;
         errors = 0;
      endfunction

      static function longint unsigned root64(longint unsigned s);
         longint unsigned r, b;
         r = 0;
         b = 64'd1 << 62;
         while (b > s) b = b >> 2;
         while (b != 0) begin
            if (s >= r + b) begin
               s = s - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         return r;
      endfunction

      // work out the expected result of an accepted request beat
      function void note_request(logic op, logic [15:0] a, logic [15:0] b, logic [15:0] c,
                                 logic signed [23:0] px, logic signed [23:0] py,
                                 logic signed [23:0] pz, logic lf);
         normal_exp_type e;
         longint cr [3];
         longint unsigned m [3];
         longint unsigned mx, s, len, q;
         longint e1x, e1y, e1z, e2x, e2y, e2z;
         int lim;
         e.nx = 0; e.ny = 0; e.nz = 0; e.last = lf;
         if (op == tfn_pkg::OP_WRITE) begin
            if (a < tfn_pkg::VERTS_MAX) begin
               vx[a] = px; vy[a] = py; vz[a] = pz;
               e.status = tfn_pkg::STAT_WRITTEN;
            end else begin
               e.status = tfn_pkg::STAT_BAD;
            end
         end else begin
            lim = (vcount < tfn_pkg::VERTS_MAX) ? vcount : tfn_pkg::VERTS_MAX;
            if (a >= lim || b >= lim || c >= lim) begin
               e.status = tfn_pkg::STAT_BAD;
            end else begin
               e1x = longint'(vx[b]) - vx[a]; e1y = longint'(vy[b]) - vy[a];
               e1z = longint'(vz[b]) - vz[a]; e2x = longint'(vx[c]) - vx[a];
               e2y = longint'(vy[c]) - vy[a]; e2z = longint'(vz[c]) - vz[a];
               cr[0] = e1y * e2z - e1z * e2y;
               cr[1] = e1z * e2x - e1x * e2z;
               cr[2] = e1x * e2y - e1y * e2x;
               for (int k = 0; k < 3; k++) m[k] = cr[k] < 0 ? -cr[k] : cr[k];
               mx = m[0];
               if (m[1] > mx) mx = m[1];
               if (m[2] > mx) mx = m[2];
               if (mx == 0) begin
                  e.status = tfn_pkg::STAT_DEGEN;
               end else begin
                  while (mx >= (64'd1 << 30)) begin
                     mx = mx >> 1;
                     for (int k = 0; k < 3; k++) m[k] = m[k] >> 1;
                  end
                  while (mx < (64'd1 << 29)) begin
                     mx = mx << 1;
                     for (int k = 0; k < 3; k++) m[k] = m[k] << 1;
                  end
                  s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
                  len = root64(s);
                  q = (m[0] * 16384 + (len >> 1)) / len;
                  e.nx = cr[0] < 0 ? -16'(q) : 16'(q);
                  q = (m[1] * 16384 + (len >> 1)) / len;
                  e.ny = cr[1] < 0 ? -16'(q) : 16'(q);
                  q = (m[2] * 16384 + (len >> 1)) / len;
                  e.nz = cr[2] < 0 ? -16'(q) : 16'(q);
                  e.status = tfn_pkg::STAT_OK;
               end
            end
         end
         pending.push_back(e);
      endfunction

      // compare a result beat with the oldest expectation
      function void check_result(logic signed [15:0] nx, logic signed [15:0] ny,
                                 logic signed [15:0] nz, logic [1:0] st, logic lo);
         normal_exp_type e;
         if (pending.size() == 0) begin
            $error("result beat with nothing expected");
            errors++;
            return;
         end
         e = pending.pop_front();
         if (nx !== e.nx) begin
            $error("normal_x expected %0d got %0d", e.nx, nx); errors++;
         end
         if (ny !== e.ny) begin
            $error("normal_y expected %0d got %0d", e.ny, ny); errors++;
         end
         if (nz !== e.nz) begin
            $error("normal_z expected %0d got %0d", e.nz, nz); errors++;
         end
         if (st !== e.status) begin
            $error("status expected %0d got %0d", e.status, st); errors++;
         end
         if (lo !== e.last) begin
            $error("last_out expected %0d got %0d", e.last, lo); errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [tfn_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [tfn_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [tfn_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   tfn_req_if req_ch ();
   tfn_rsp_if rsp_ch ();

   triangle_face_normal dut (
      .clock(clock), .reset(reset), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   normal_scoreboard board = new();
   int idle_pct = 0;
   int stall_pct = 0;
   int hold_cycles = 0;
   bit written [tfn_pkg::VERTS_MAX];
   int written_list [$];

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   // result side: random stall, long hold-off, check on accepted beats
   initial begin
      rsp_ch.ready = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready)
            board.check_result(rsp_ch.normal_x, rsp_ch.normal_y, rsp_ch.normal_z,
                               rsp_ch.status, rsp_ch.last_out);
         @(negedge clock);
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_ch.ready <= 0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // register write: setup then access cycle
   task automatic write_count(logic [10:0] value);
      csr_psel <= 1; csr_pwrite <= 1; csr_penable <= 0;
      csr_paddr <= tfn_pkg::CSR_ADDR_W'(tfn_pkg::CSR_IDX_VERTEX_COUNT) << 2;
      csr_pwdata <= tfn_pkg::CSR_DATA_W'(value);
      @(negedge clock);
      csr_penable <= 1;
      @(posedge clock);
      board.vcount = value;
      @(negedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
   endtask

   // one request beat, held until accepted
   task automatic send_beat(logic op, logic [15:0] a, logic [15:0] b, logic [15:0] c,
                            logic [23:0] px, logic [23:0] py, logic [23:0] pz, logic lf);
      while ($urandom_range(99) < idle_pct) begin
         req_ch.valid <= 0;
         @(negedge clock);
      end
      req_ch.valid <= 1; req_ch.op <= op;
      req_ch.corner_a <= a; req_ch.corner_b <= b; req_ch.corner_c <= c;
      req_ch.pos_x <= px; req_ch.pos_y <= py; req_ch.pos_z <= pz; req_ch.last_face <= lf;
      do @(posedge clock); while (!req_ch.ready);
      board.note_request(op, a, b, c, px, py, pz, lf);
      if (op == tfn_pkg::OP_WRITE && a < tfn_pkg::VERTS_MAX && !written[a]) begin
         written[a] = 1;
         written_list.push_back(a);
      end
      @(negedge clock);
   endtask

   task automatic drain();
      req_ch.valid <= 0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (70) @(negedge clock);
   endtask

   // the other corners come from written entries, bad ones lie at or above the limit
   function automatic logic [15:0] pick_corner(int bad_pct);
      int lim;
      lim = (board.vcount < tfn_pkg::VERTS_MAX) ? int'(board.vcount) : tfn_pkg::VERTS_MAX;
      if ($urandom_range(99) < bad_pct)
         return ($urandom_range(1)) ? 16'($urandom_range(65535, lim)) : 16'(board.vcount);
      return 16'(written_list[$urandom_range(written_list.size() - 1)]);
   endfunction

   // random coordinate: half small, otherwise full range or an extreme
   function automatic logic [23:0] rand_coord();
      case ($urandom_range(3))
         0: return 24'($urandom);
         1: return $urandom_range(1) ? 24'h7fffff : 24'h800000;
         default: return 24'($signed($urandom_range(4000)) - 2000);
      endcase
   endfunction

   task automatic random_phase(int n, int vmax);
      int a;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < 25 || written_list.size() < 3) begin
            a = ($urandom_range(49) == 0) ? $urandom_range(65535) : $urandom_range(vmax - 1);
            send_beat(tfn_pkg::OP_WRITE, 16'(a), 16'($urandom), 16'($urandom), rand_coord(),
                      rand_coord(), rand_coord(), 1'($urandom));
         end else begin
            send_beat(tfn_pkg::OP_FACE, pick_corner(6), pick_corner(6), pick_corner(6),
                      24'($urandom), 24'($urandom), 24'($urandom), 1'($urandom));
         end
      end
   endtask

   initial begin
      req_ch.valid = 0; req_ch.op = tfn_pkg::OP_WRITE; req_ch.corner_a = 0;
      req_ch.corner_b = 0; req_ch.corner_c = 0; req_ch.pos_x = 0; req_ch.pos_y = 0;
      req_ch.pos_z = 0; req_ch.last_face = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // directed: face with count zero, writes at extremes, special faces
      send_beat(tfn_pkg::OP_FACE, 0, 0, 0, 0, 0, 0, 1);
      drain();
      write_count(11'd2047);
      send_beat(tfn_pkg::OP_WRITE, 0, 16'hffff, 16'hffff, 24'h800000, 24'h800000,
                24'h800000, 0);
      send_beat(tfn_pkg::OP_WRITE, 1, 0, 0, 24'h7fffff, 24'h7fffff, 24'h7fffff, 1);
      send_beat(tfn_pkg::OP_WRITE, 2, 0, 0, 24'h7fffff, 24'h800000, 24'h000000, 0);
      send_beat(tfn_pkg::OP_WRITE, 1023, 0, 0, 24'h000100, 0, 0, 0);
      send_beat(tfn_pkg::OP_WRITE, 16'hffff, 0, 0, 1, 2, 3, 0);
      send_beat(tfn_pkg::OP_WRITE, 1024, 0, 0, 1, 2, 3, 1);
      send_beat(tfn_pkg::OP_WRITE, 3, 0, 0, 0, 24'h000100, 0, 0);
      send_beat(tfn_pkg::OP_WRITE, 4, 0, 0, 0, 0, 24'h000100, 0);
      send_beat(tfn_pkg::OP_WRITE, 5, 0, 0, 0, 0, 0, 0);
      send_beat(tfn_pkg::OP_FACE, 0, 1, 2, 0, 0, 0, 0);
      send_beat(tfn_pkg::OP_FACE, 5, 1023, 3, 0, 0, 0, 1);
      send_beat(tfn_pkg::OP_FACE, 5, 3, 1023, 0, 0, 0, 0);
      send_beat(tfn_pkg::OP_FACE, 0, 0, 1, 0, 0, 0, 0);
      send_beat(tfn_pkg::OP_FACE, 0, 1, 5, 0, 0, 0, 0);
      send_beat(tfn_pkg::OP_FACE, 0, 1, 1024, 0, 0, 0, 1);
      send_beat(tfn_pkg::OP_FACE, 16'hffff, 0, 1, 0, 0, 0, 0);
      drain();
      write_count(11'd4);
      send_beat(tfn_pkg::OP_FACE, 0, 1, 2, 0, 0, 0, 0);
      send_beat(tfn_pkg::OP_FACE, 0, 1, 4, 0, 0, 0, 1);
      drain();

      // random phases over settings and idling mixes
      write_count(11'd1024);
      random_phase(300, 1024);
      drain();
      write_count(11'd16); idle_pct = 88;
      random_phase(150, 16);
      drain();
      write_count(11'd3); idle_pct = 0; stall_pct = 88;
      random_phase(150, 3);
      drain();
      write_count(11'd1); idle_pct = 37; stall_pct = 37;
      random_phase(100, 3);
      drain();
      write_count(11'd0);
      random_phase(60, 8);
      drain();
      write_count(11'd64); idle_pct = 0; stall_pct = 0;
      hold_cycles = 150;
      random_phase(250, 64);
      drain();
      write_count(11'd1500); idle_pct = 37; stall_pct = 37;
      random_phase(300, 1024);
      drain();

      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // run limit
   initial begin
      #6000000;
      $display("FAILURE");
      $finish;
   end
endmodule

### sim.f
+incdir+src
src/tfn_pkg.sv
src/tfn_ifs.sv
src/tfn_ram.sv
src/tfn_front.sv
src/tfn_norm.sv
src/tfn_div.sv
src/triangle_face_normal.sv
src/tfn_checker.sv
tb/testbench.sv
